// ----- rtl/wvs_pkg.sv -----
// Package for window_variation_sum: widths, reset values and sequencer states.
// Used by rtl/window_variation_sum.sv and rtl/window_variation_sum_chk.sv.
`timescale 1ns / 1ps

package wvs_pkg;

    localparam int SAMPLE_WIDTH_DEFAULT = 32;
    localparam int CFG_W                = 32;
    localparam int SUM_W                = 64;
    localparam int MEASURE_W            = 63;
    localparam int FRAC_BITS            = 16;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 32'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV_SEG,
        ST_SEG_DONE,
        ST_MUL,
        ST_DIV_INT,
        ST_EDGE,
        ST_FINISH,
        ST_CLOSE,
        ST_DIV_OUT,
        ST_OUT
    } state_t;

endpackage

// ----- rtl/window_variation_sum.sv -----
// window_variation_sum top level: sequencer around one shared shift-add
// multiply / restoring divide unit. Depends on wvs_pkg.
`timescale 1ns / 1ps

// Takes (x, y) samples one word at a time and, on the word flagged last,
// returns the sum of per-window y ranges divided by the window width
// (Q47.16, saturated). s_ready is high only while the block is idle. A word
// that passes window edges adds an edge count division and, per interpolated
// edge (the first, and the last if more), a multiply and a division. The last
// word adds the final division, plus any wait for a previous result still
// held at the output. All of it runs through one bit-serial multiply/divide
// unit, NW = max(2*W, 80) bits wide with W = SAMPLE_WIDTH. The result waits
// in an output register while the next stream starts.
module window_variation_sum #(
    parameter int SAMPLE_WIDTH = wvs_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [wvs_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [SAMPLE_WIDTH-1:0]        s_x_pos,
    input  logic signed [SAMPLE_WIDTH-1:0] s_y_val,
    input  logic                           s_last_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [wvs_pkg::MEASURE_W-1:0]  m_variation_measure,
    output logic                           m_saturated
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int DW  = (W > wvs_pkg::CFG_W) ? W : wvs_pkg::CFG_W;
    localparam int EW  = DW + 1;
    localparam int NW  = (2 * W > wvs_pkg::SUM_W + wvs_pkg::FRAC_BITS) ?
                         2 * W : wvs_pkg::SUM_W + wvs_pkg::FRAC_BITS;
    localparam int CW  = $clog2(NW + 1);
    localparam int SW  = wvs_pkg::SUM_W;
    localparam int MW  = wvs_pkg::MEASURE_W;

    wvs_pkg::state_t state_reg, state_next;

    logic [wvs_pkg::CFG_W-1:0] width_reg;
    logic [wvs_pkg::CFG_W-1:0] dx;

    logic [W-1:0]        x_reg, x_next;
    logic signed [W-1:0] y_reg, y_next;
    logic                last_reg, last_next;
    logic                active_reg, active_next;
    logic [EW-1:0]       end_reg, end_next;
    logic signed [W-1:0] low_reg, low_next;
    logic signed [W-1:0] high_reg, high_next;
    logic [W-1:0]        prev_x_reg, prev_x_next;
    logic signed [W-1:0] prev_y_reg, prev_y_next;
    logic [SW-1:0]       sum_reg, sum_next;
    logic                ovf_reg, ovf_next;
    logic [W-1:0]        ledge_reg, ledge_next;
    logic                steps_nz_reg, steps_nz_next;
    logic                second_reg, second_next;
    logic                neg_reg, neg_next;
    logic signed [W-1:0] yfirst_reg, yfirst_next;
    logic [W-1:0]        mag_reg, mag_next;
    logic [W-1:0]        mulb_reg, mulb_next;

    // shared multiply/divide unit
    logic [NW-1:0]       acc_reg, acc_next;
    logic [DW:0]         rem_reg, rem_next;
    logic [DW-1:0]       den_reg, den_next;
    logic [CW-1:0]       cnt_reg, cnt_next;

    logic                mv_reg, mv_next;
    logic [MW-1:0]       meas_reg, meas_next;
    logic                sat_reg, sat_next;

    // datapath helpers
    logic [DW:0]         rem_sh;
    logic                div_ge;
    logic [DW:0]         div_rem;
    logic [NW-1:0]       div_acc;
    logic [NW-1:0]       mul_acc;
    logic [EW-1:0]       x_ext;
    logic [EW-1:0]       xd;
    logic signed [W:0]   dy;
    logic [W-1:0]        off;
    logic signed [W-1:0] yv;
    logic signed [W-1:0] lo_w, hi_w;
    logic signed [W:0]   d_edge;
    logic [SW-1:0]       add_val;
    logic [SW:0]         add_sum;
    logic [SW-1:0]       sum_sat;
    logic                add_ovf;

    function automatic logic [SW-1:0] range_of(input logic signed [W-1:0] hi,
                                               input logic signed [W-1:0] lo);
        logic signed [W:0] d;
        d = $signed({hi[W-1], hi}) - $signed({lo[W-1], lo});
        return {{(SW-W-1){1'b0}}, d};
    endfunction

    function automatic logic [SW-1:0] abs_of(input logic signed [W:0] d);
        logic [W:0] m;
        m = d[W] ? -d : d;
        return {{(SW-W-1){1'b0}}, m};
    endfunction

    assign dx = (width_reg == '0) ? {{(wvs_pkg::CFG_W-1){1'b0}}, 1'b1} : width_reg;

    assign rem_sh  = {rem_reg[DW-1:0], acc_reg[NW-1]};
    assign div_ge  = rem_sh >= {1'b0, den_reg};
    assign div_rem = div_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
    assign div_acc = {acc_reg[NW-2:0], div_ge};
    assign mul_acc = {acc_reg[NW-2:0], 1'b0}
                     + (mulb_reg[W-1] ? {{(NW-W){1'b0}}, mag_reg} : '0);

    assign x_ext  = {{(EW-W){1'b0}}, x_reg};
    assign xd     = x_ext - end_reg;
    assign dy     = $signed({y_reg[W-1], y_reg}) - $signed({prev_y_reg[W-1], prev_y_reg});
    assign off    = acc_reg[W-1:0];
    assign yv     = neg_reg ? prev_y_reg - $signed(off) : prev_y_reg + $signed(off);
    assign lo_w   = (yv < low_reg) ? yv : low_reg;
    assign hi_w   = (yv > high_reg) ? yv : high_reg;
    assign d_edge = $signed({yv[W-1], yv}) - $signed({yfirst_reg[W-1], yfirst_reg});

    always_comb begin
        case (state_reg)
            wvs_pkg::ST_EDGE:  add_val = second_reg ? abs_of(d_edge) : range_of(hi_w, lo_w);
            wvs_pkg::ST_CLOSE: add_val = range_of(high_reg, low_reg);
            default:           add_val = '0;
        endcase
    end

    assign add_sum = {1'b0, sum_reg} + {1'b0, add_val};
    assign add_ovf = add_sum[SW];
    assign sum_sat = add_ovf ? '1 : add_sum[SW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= wvs_pkg::ST_IDLE;
            width_reg  <= wvs_pkg::WIDTH_RESET;
            active_reg <= 1'b0;
            mv_reg     <= 1'b0;
            end_reg    <= '0;
            low_reg    <= '0;
            high_reg   <= '0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            sum_reg    <= '0;
            ovf_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            if (cfg_we) begin
                width_reg <= cfg_wdata;
            end
            active_reg <= active_next;
            mv_reg     <= mv_next;
            end_reg    <= end_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            prev_x_reg <= prev_x_next;
            prev_y_reg <= prev_y_next;
            sum_reg    <= sum_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        last_reg     <= last_next;
        ledge_reg    <= ledge_next;
        steps_nz_reg <= steps_nz_next;
        second_reg   <= second_next;
        neg_reg      <= neg_next;
        yfirst_reg   <= yfirst_next;
        mag_reg      <= mag_next;
        mulb_reg     <= mulb_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        cnt_reg      <= cnt_next;
        meas_reg     <= meas_next;
        sat_reg      <= sat_next;
    end

    always_comb begin
        state_next    = state_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        last_next     = last_reg;
        active_next   = active_reg;
        end_next      = end_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        prev_x_next   = prev_x_reg;
        prev_y_next   = prev_y_reg;
        sum_next      = sum_reg;
        ovf_next      = ovf_reg;
        ledge_next    = ledge_reg;
        steps_nz_next = steps_nz_reg;
        second_next   = second_reg;
        neg_next      = neg_reg;
        yfirst_next   = yfirst_reg;
        mag_next      = mag_reg;
        mulb_next     = mulb_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        cnt_next      = cnt_reg;
        meas_next     = meas_reg;
        sat_next      = sat_reg;
        mv_next       = mv_reg && !m_ready;

        case (state_reg)
            wvs_pkg::ST_IDLE: begin
                if (s_valid) begin
                    x_next     = s_x_pos;
                    y_next     = s_y_val;
                    last_next  = s_last_sample;
                    state_next = wvs_pkg::ST_LOAD;
                end
            end
            wvs_pkg::ST_LOAD: begin
                if (!active_reg) begin
                    active_next = 1'b1;
                    sum_next    = '0;
                    ovf_next    = 1'b0;
                    low_next    = y_reg;
                    high_next   = y_reg;
                    end_next    = x_ext + {{(EW-wvs_pkg::CFG_W){1'b0}}, dx};
                    prev_x_next = x_reg;
                    prev_y_next = y_reg;
                    state_next  = wvs_pkg::ST_CLOSE;
                end else if (x_ext >= end_reg && x_reg > prev_x_reg) begin
                    // edge count: remainder of (x - end) / dx places the last edge
                    acc_next   = {{(NW-EW){1'b0}}, xd};
                    rem_next   = '0;
                    den_next   = DW'(dx);
                    cnt_next   = CW'(NW);
                    state_next = wvs_pkg::ST_DIV_SEG;
                end else begin
                    state_next = wvs_pkg::ST_FINISH;
                end
            end
            wvs_pkg::ST_DIV_SEG: begin
                acc_next = div_acc;
                rem_next = div_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    state_next = wvs_pkg::ST_SEG_DONE;
                end
            end
            wvs_pkg::ST_SEG_DONE: begin
                ledge_next    = x_reg - rem_reg[W-1:0];
                steps_nz_next = acc_reg != '0;
                second_next   = 1'b0;
                neg_next      = dy[W];
                mag_next      = dy[W] ? W'(-dy) : dy[W-1:0];
                mulb_next     = W'(end_reg - {{(EW-W){1'b0}}, prev_x_reg});
                acc_next      = '0;
                cnt_next      = CW'(W);
                state_next    = wvs_pkg::ST_MUL;
            end
            wvs_pkg::ST_MUL: begin
                acc_next  = mul_acc;
                mulb_next = {mulb_reg[W-2:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    rem_next   = '0;
                    den_next   = DW'(W'(x_reg - prev_x_reg));
                    cnt_next   = CW'(NW);
                    state_next = wvs_pkg::ST_DIV_INT;
                end
            end
            wvs_pkg::ST_DIV_INT: begin
                acc_next = div_acc;
                rem_next = div_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    state_next = wvs_pkg::ST_EDGE;
                end
            end
            wvs_pkg::ST_EDGE: begin
                sum_next = sum_sat;
                ovf_next = ovf_reg | add_ovf;
                if (!second_reg && steps_nz_reg) begin
                    low_next    = lo_w;
                    high_next   = hi_w;
                    yfirst_next = yv;
                    second_next = 1'b1;
                    mulb_next   = ledge_reg - prev_x_reg;
                    acc_next    = '0;
                    cnt_next    = CW'(W);
                    state_next  = wvs_pkg::ST_MUL;
                end else begin
                    // new window opens at the last edge passed
                    low_next   = yv;
                    high_next  = yv;
                    end_next   = {{(EW-W){1'b0}}, ledge_reg}
                                 + {{(EW-wvs_pkg::CFG_W){1'b0}}, dx};
                    state_next = wvs_pkg::ST_FINISH;
                end
            end
            wvs_pkg::ST_FINISH: begin
                if (y_reg < low_reg) begin
                    low_next = y_reg;
                end
                if (y_reg > high_reg) begin
                    high_next = y_reg;
                end
                prev_x_next = x_reg;
                prev_y_next = y_reg;
                state_next  = wvs_pkg::ST_CLOSE;
            end
            wvs_pkg::ST_CLOSE: begin
                if (last_reg) begin
                    sum_next    = sum_sat;
                    ovf_next    = ovf_reg | add_ovf;
                    active_next = 1'b0;
                    acc_next    = NW'({sum_sat, {wvs_pkg::FRAC_BITS{1'b0}}});
                    rem_next    = '0;
                    den_next    = DW'(dx);
                    cnt_next    = CW'(NW);
                    state_next  = wvs_pkg::ST_DIV_OUT;
                end else begin
                    state_next = wvs_pkg::ST_IDLE;
                end
            end
            wvs_pkg::ST_DIV_OUT: begin
                acc_next = div_acc;
                rem_next = div_rem;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    state_next = wvs_pkg::ST_OUT;
                end
            end
            wvs_pkg::ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    if (acc_reg[NW-1:MW] != '0) begin
                        meas_next = '1;
                        sat_next  = 1'b1;
                    end else begin
                        meas_next = acc_reg[MW-1:0];
                        sat_next  = ovf_reg;
                    end
                    state_next = wvs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wvs_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_ready             = state_reg == wvs_pkg::ST_IDLE;
    assign m_valid             = mv_reg;
    assign m_variation_measure = meas_reg;
    assign m_saturated         = sat_reg;

endmodule

// ----- rtl/window_variation_sum_chk.sv -----
// Port-level checker for window_variation_sum, bound to the top level.
// Depends on wvs_pkg and window_variation_sum.
`timescale 1ns / 1ps

module window_variation_sum_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_last_sample,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [wvs_pkg::MEASURE_W-1:0] m_variation_measure,
    input logic                          m_saturated
);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_variation_measure)
                                && $stable(m_saturated))
        else $error("result word changed while stalled");

    // one word at a time: busy right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after accept");

    // only a last word produces a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_last_sample |=> ##1 !$rose(m_valid))
        else $error("result after non-last word");

    // a result is posted as the block goes idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result posted while busy");

endmodule

bind window_variation_sum window_variation_sum_chk u_chk (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .s_last_sample       (s_last_sample),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_variation_measure (m_variation_measure),
    .m_saturated         (m_saturated)
);

// ----- dv/window_variation_sum_test.sv -----
// Self-checking testbench for window_variation_sum: random (x, y) streams under
// several window widths and handshake idling patterns. Depends on wvs_pkg and the RTL.
`timescale 1ns / 1ps

module window_variation_sum_test;

    localparam int W          = 32;
    localparam int DRAIN_WAIT = 700;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [wvs_pkg::MEASURE_W-1:0] measure;
        logic                          sat;
    } measure_t;

    class variation_board;
        logic [wvs_pkg::CFG_W-1:0] width;
        bit               active;
        logic [63:0]      edge_x;
        longint           win_lo, win_hi;
        logic [63:0]      prev_x;
        longint           prev_y;
        logic [63:0]      range_sum;
        bit               overflowed;
        measure_t         pending[$];
        int               mismatches;

        function new();
            width = wvs_pkg::WIDTH_RESET;
            active = 0;
            edge_x = 0;
            win_lo = 0;
            win_hi = 0;
            prev_x = 0;
            prev_y = 0;
            range_sum = 0;
            overflowed = 0;
            mismatches = 0;
        endfunction

        function longint edge_y(logic [63:0] xc, longint yc, logic [63:0] e);
            logic [63:0]  span, mag, off;
            logic [127:0] prod;
            longint       dy;
            if (xc <= prev_x) return yc;
            span = xc - prev_x;
            dy = yc - prev_y;
            mag = dy < 0 ? -dy : dy;
            prod = mag * (e - prev_x);
            off = prod / span;
            return dy < 0 ? prev_y - longint'(off) : prev_y + longint'(off);
        endfunction

        function void add_range(logic [63:0] v);
            if (range_sum > ~64'd0 - v) begin
                range_sum = ~64'd0;
                overflowed = 1;
            end else begin
                range_sum = range_sum + v;
            end
        endfunction

        function void widen(longint y);
            if (y < win_lo) win_lo = y;
            if (y > win_hi) win_hi = y;
        endfunction

        function void note_sample(logic [W-1:0] x, logic signed [W-1:0] ys, bit last);
            logic [63:0] xv, dx, steps, last_edge, whole, rem;
            longint      yv, y_first, y_last, d;
            measure_t    m;
            xv = x;
            yv = ys;
            dx = (width == 0) ? 64'd1 : 64'(width);
            if (!active) begin
                active = 1;
                range_sum = 0;
                overflowed = 0;
                win_lo = yv;
                win_hi = yv;
                edge_x = xv + dx;
            end else begin
                if (xv >= edge_x && xv > prev_x) begin
                    steps = (xv - edge_x) / dx;
                    last_edge = edge_x + steps * dx;
                    y_first = edge_y(xv, yv, edge_x);
                    y_last = y_first;
                    widen(y_first);
                    add_range(64'(win_hi - win_lo));
                    if (steps != 0) begin
                        y_last = edge_y(xv, yv, last_edge);
                        d = y_last - y_first;
                        add_range(d < 0 ? 64'(-d) : 64'(d));
                    end
                    win_lo = y_last;
                    win_hi = y_last;
                    edge_x = last_edge + dx;
                end
                widen(yv);
            end
            prev_x = xv;
            prev_y = yv;
            if (!last) return;
            add_range(64'(win_hi - win_lo));
            whole = range_sum / dx;
            rem = range_sum % dx;
            m.sat = overflowed;
            if (whole >= (64'd1 << 47)) begin
                m.measure = {wvs_pkg::MEASURE_W{1'b1}};
                m.sat = 1;
            end else begin
                m.measure = wvs_pkg::MEASURE_W'((whole << 16) + ((rem << 16) / dx));
            end
            pending.push_back(m);
            active = 0;
        endfunction

        function void check_result(logic [wvs_pkg::MEASURE_W-1:0] measure, logic sat);
            measure_t exp_m;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word measure=%h sat=%b", measure, sat);
                return;
            end
            exp_m = pending.pop_front();
            if (measure !== exp_m.measure || sat !== exp_m.sat) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: measure exp %h got %h, sat exp %b got %b",
                             exp_m.measure, measure, exp_m.sat, sat);
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [wvs_pkg::CFG_W-1:0]     cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    logic [W-1:0]                  s_x_pos;
    logic signed [W-1:0]           s_y_val;
    logic                          s_last_sample;
    logic                          m_valid;
    logic                          m_ready;
    logic [wvs_pkg::MEASURE_W-1:0] m_variation_measure;
    logic                          m_saturated;

    variation_board sb = new();
    int  send_idle_pct;
    int  recv_stall_pct;
    int  quiet_cycles;
    int  samples_sent;

    window_variation_sum #(.SAMPLE_WIDTH(W)) DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_x_pos            (s_x_pos),
        .s_y_val            (s_y_val),
        .s_last_sample      (s_last_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_variation_measure(m_variation_measure),
        .m_saturated        (m_saturated)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // result side: check, random stall, watchdog on words moved
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_variation_measure, m_saturated);
            if ((m_valid && m_ready) || (s_valid && s_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_sample(logic [W-1:0] x, logic [W-1:0] y, bit last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid       <= 1'b1;
        s_x_pos       <= x;
        s_y_val       <= y;
        s_last_sample <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(x, y, last);
        samples_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_width(logic [wvs_pkg::CFG_W-1:0] w);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.width = w;
    endtask

    function automatic logic [W-1:0] pick_y(logic [W-1:0] prev);
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return prev + $urandom_range(512) - 256;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_stream(int len);
        logic [63:0]  dx, xn;
        logic [W-1:0] x, y;
        dx = (sb.width == 0) ? 64'd1 : 64'(sb.width);
        x = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1 << 20);
        y = $urandom;
        for (int i = 0; i < len; i++) begin
            if (i != 0) begin
                case ($urandom_range(9))
                    0: xn = x;                                     // repeated x
                    1: xn = x - $urandom_range(dx > 64 ? 64 : 1); // x steps back
                    2: xn = x + dx;                                // one window width on
                    3: xn = x + dx * $urandom_range(8);
                    4: xn = x + $urandom;                          // very long segment
                    default: xn = x + ((dx * $urandom_range(3)) >> 1) + $urandom_range(255);
                endcase
                x = (xn > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : xn[W-1:0];
            end
            y = pick_y(y);
            send_sample(x, y, i == len - 1);
        end
    endtask

    initial begin
        logic [wvs_pkg::CFG_W-1:0] widths[8];
        int                        idle_modes[4][2];
        aresetn        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        s_valid        <= 1'b0;
        s_x_pos        <= '0;
        s_y_val        <= '0;
        s_last_sample  <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        samples_sent   = 0;
        widths = '{32'd65536, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd4096,
                   32'd300000, 32'h0001_8000, 32'd17};
        idle_modes = '{'{0, 0}, '{80, 0}, '{0, 80}, '{12, 12}};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset width, extremes, edge hits, repeats, step back, many edges
        send_sample(32'd123, 32'hFFFF_FFFF, 1);              // single-sample stream
        send_sample(32'd0, 32'h7FFF_FFFF, 0);
        send_sample(32'h0001_0000, 32'h8000_0000, 0);        // exactly on an edge
        send_sample(32'h0001_0000, 32'd5, 0);                // same x again
        send_sample(32'h0000_8000, 32'd100, 0);              // x below previous
        send_sample(32'h0005_1234, 32'hFFFF_FFF9, 0);        // several edges at once
        send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1);        // huge jump, last
        send_sample(32'hFFFF_FFFF, 32'h8000_0000, 0);
        send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1);        // all at top of x range
        send_sample(32'd0, 32'd0, 0);
        send_sample(32'h0000_FFFF, 32'd65536, 0);
        send_sample(32'h0002_0000, 32'hFFFF_0000, 1);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            write_width(widths[p]);
            send_idle_pct  = idle_modes[p % 4][0];
            recv_stall_pct = idle_modes[p % 4][1];
            while (samples_sent < 12 + (p + 1) * 186)
                run_stream(($urandom_range(3) == 0) ? 1 : $urandom_range(2, 16));
            wait_drained();
        end

        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
